### src/jfss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfss_pkg
// Shared types and constants for the JPEG frame size scanner.
// ----------------------------------------------------------------------------
package jfss_pkg;

  localparam logic [7:0] MARKER_PREFIX = 8'hFF;
  localparam logic [7:0] MARKER_SOI    = 8'hD8;
  localparam logic [7:0] MARKER_SOF0   = 8'hC0;
  localparam logic [7:0] MARKER_SOF2   = 8'hC2;

  localparam int DIM_W = 16;

  // Frame header: height sits in bytes 3..4 after the marker, width in 5..6.
  localparam logic [2:0] FRAME_HEIGHT_HI = 3'd3;
  localparam logic [2:0] FRAME_HEIGHT_LO = 3'd4;
  localparam logic [2:0] FRAME_WIDTH_HI  = 3'd5;
  localparam logic [2:0] FRAME_WIDTH_LO  = 3'd6;

  typedef enum logic [8:0] {
    PH_SOI0  = 9'b000000001,
    PH_SOI1  = 9'b000000010,
    PH_MARK  = 9'b000000100,
    PH_FILL  = 9'b000001000,
    PH_LENH  = 9'b000010000,
    PH_LENL  = 9'b000100000,
    PH_SKIP  = 9'b001000000,
    PH_FRAME = 9'b010000000,
    PH_DONE  = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic             found;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } result_t;

endpackage

### src/jfss_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jfss_parser
// Byte-wise marker walker; updates its state on every accepted word and
// flags at most one result per word.
// ----------------------------------------------------------------------------
module jfss_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        data_byte,
  input  wire logic              final_byte,
  output      logic              res_valid,
  output      jfss_pkg::result_t res
);

  jfss_pkg::phase_t phase, phase_next;
  logic [15:0] skip_remaining, skip_remaining_next;
  logic [2:0]  frame_byte_index, frame_byte_index_next;
  logic [15:0] held_height, held_height_next;
  logic [7:0]  length_high, length_high_next;

  logic        fail;
  logic        hit;
  logic [15:0] seg_len;
  logic [15:0] skip_dec;

  assign seg_len  = {length_high, data_byte};
  assign skip_dec = skip_remaining - 16'd1;

  always_comb begin
    phase_next            = phase;
    skip_remaining_next   = skip_remaining;
    frame_byte_index_next = frame_byte_index;
    held_height_next      = held_height;
    length_high_next      = length_high;
    fail                  = 1'b0;
    hit                   = 1'b0;

    unique case (phase)
      jfss_pkg::PH_SOI0: begin
        if (data_byte == jfss_pkg::MARKER_PREFIX) phase_next = jfss_pkg::PH_SOI1;
        else fail = 1'b1;
      end
      jfss_pkg::PH_SOI1: begin
        if (data_byte == jfss_pkg::MARKER_SOI) phase_next = jfss_pkg::PH_MARK;
        else fail = 1'b1;
      end
      jfss_pkg::PH_MARK: begin
        if (data_byte == jfss_pkg::MARKER_PREFIX) phase_next = jfss_pkg::PH_FILL;
        else fail = 1'b1;
      end
      jfss_pkg::PH_FILL: begin
        // extra FF bytes are fill; stay put
        if (data_byte == jfss_pkg::MARKER_SOF0 || data_byte == jfss_pkg::MARKER_SOF2) begin
          frame_byte_index_next = 3'd0;
          phase_next            = jfss_pkg::PH_FRAME;
        end else if (data_byte != jfss_pkg::MARKER_PREFIX) begin
          phase_next = jfss_pkg::PH_LENH;
        end
      end
      jfss_pkg::PH_LENH: begin
        length_high_next = data_byte;
        phase_next       = jfss_pkg::PH_LENL;
      end
      jfss_pkg::PH_LENL: begin
        if (seg_len < 16'd2) begin
          fail = 1'b1;
        end else if (seg_len == 16'd2) begin
          phase_next = jfss_pkg::PH_MARK;
        end else begin
          skip_remaining_next = seg_len - 16'd2;
          phase_next          = jfss_pkg::PH_SKIP;
        end
      end
      jfss_pkg::PH_SKIP: begin
        // count is never zero here, so a plain decrement is safe
        skip_remaining_next = skip_dec;
        if (skip_dec == 16'd0) phase_next = jfss_pkg::PH_MARK;
      end
      jfss_pkg::PH_FRAME: begin
        frame_byte_index_next = frame_byte_index + 3'd1;
        case (frame_byte_index)
          jfss_pkg::FRAME_HEIGHT_HI: held_height_next = {data_byte, 8'h00};
          jfss_pkg::FRAME_HEIGHT_LO: held_height_next = {held_height[15:8], data_byte};
          jfss_pkg::FRAME_WIDTH_HI:  length_high_next = data_byte;
          jfss_pkg::FRAME_WIDTH_LO: begin
            hit                   = 1'b1;
            frame_byte_index_next = frame_byte_index;
            phase_next            = jfss_pkg::PH_DONE;
          end
          default: ;
        endcase
      end
      jfss_pkg::PH_DONE: ;
      default: ;
    endcase

    if (fail) phase_next = jfss_pkg::PH_DONE;
  end

  // One result per file: on a hit, a failure, or an unanswered final word.
  always_comb begin
    res_valid        = accept && (hit || fail ||
                                  (final_byte && phase != jfss_pkg::PH_DONE));
    res.found        = hit;
    res.image_width  = hit ? seg_len : 16'd0;
    res.image_height = hit ? held_height : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= jfss_pkg::PH_SOI0;
      skip_remaining   <= 16'd0;
      frame_byte_index <= 3'd0;
      held_height      <= 16'd0;
      length_high      <= 8'd0;
    end else if (accept) begin
      if (final_byte) begin
        // rearm for the next file
        phase            <= jfss_pkg::PH_SOI0;
        skip_remaining   <= 16'd0;
        frame_byte_index <= 3'd0;
        held_height      <= 16'd0;
        length_high      <= 8'd0;
      end else begin
        phase            <= phase_next;
        skip_remaining   <= skip_remaining_next;
        frame_byte_index <= frame_byte_index_next;
        held_height      <= held_height_next;
        length_high      <= length_high_next;
      end
    end
  end

endmodule
`default_nettype wire

### src/jfss_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jfss_out_reg
// Result register; holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module jfss_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire jfss_pkg::result_t load_res,
  input  wire logic              take,
  output      logic              full,
  output      jfss_pkg::result_t res
);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= load_res;
    end
  end

endmodule
`default_nettype wire

### src/jpeg_frame_size_scanner_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jpeg_frame_size_scanner_core
// Streams a JPEG file byte by byte and reports the frame dimensions.
// ----------------------------------------------------------------------------
// Feed one file byte per input word, with tlast on the final byte. The core
// checks the FF D8 start pair, walks marker segments (FF, optional FF fill,
// marker, 16-bit big-endian length, skip length minus 2), and on a baseline
// or progressive frame marker (C0 / C2) returns one success word carrying
// width and height. A bad start pair, a missing FF where a marker is due, a
// length below 2, or the end of the file before an answer returns one failure
// word with zero dimensions. Every file gives exactly one result word; bytes
// after the answer are dropped, and the core rearms after tlast. One input
// word is taken every clock cycle unless input is stalled; a result appears on
// the output in the cycle after the byte that decides it, held in a single
// result register. Input is stalled while reset is high, and otherwise only
// while that register is full and the sink holds tready low.
// ----------------------------------------------------------------------------
module jpeg_frame_size_scanner_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // final_byte
  // result stream
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [31:0] m_tdata,   // [15:0] image_width, [31:16] image_height
  output      logic        m_tuser    // found
);

  logic              s_accept;
  logic              res_valid;
  jfss_pkg::result_t res_in;
  jfss_pkg::result_t res_held;
  logic              out_full;

  // Take a word whenever the result slot is free or drains this cycle;
  // hold off while in reset.
  assign s_tready = !rst && (!out_full || m_tready);
  assign s_accept = s_tvalid && s_tready;

  jfss_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (s_accept),
    .data_byte  (s_tdata),
    .final_byte (s_tlast),
    .res_valid  (res_valid),
    .res        (res_in)
  );

  // Hold the result until the sink takes it.
  jfss_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .load_res (res_in),
    .take     (m_tready),
    .full     (out_full),
    .res      (res_held)
  );

  assign m_tvalid = out_full;
  assign m_tdata  = {res_held.image_height, res_held.image_width};
  assign m_tuser  = res_held.found;

endmodule
`default_nettype wire

### tb/sv/jpeg_frame_size_scanner_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_frame_size_scanner_core_tb
// Self-checking bench for the JPEG frame size scanner core.
// ----------------------------------------------------------------------------
// Streams JPEG-like files into the core, one byte per input word, and checks
// every result word against a cycle-free scanner model kept in the bench.
// A short table of hand-built files covers bad start pairs, a missing marker
// prefix, fill bytes, length 2, a short length, an early end and a frame
// header with extreme sizes. Random files follow: mostly well-formed marker
// walks ending in a C0/C2 frame header, plus truncated, corrupted,
// short-length and noise files. The source sends in bursts with random gaps,
// and the sink stalls in changing patterns, including long hold-offs, after
// file 15 and, if reached, file 35, that fill the core and stall its input.
// ----------------------------------------------------------------------------
module jpeg_frame_size_scanner_core_tb;
  import jfss_pkg::*;

  localparam int CLK_HALF         = 4;
  localparam int ITEM_TARGET      = 450;   // input words in all, table included
  localparam int FILE_TARGET      = 26;    // enough files to reach the hold-off and the drain
  localparam int SINK_HOLD_CYCLES = 160;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int N_ROWS           = 31;

  // How a table row is checked: through the scanner model, or against a
  // result, or the lack of one, typed into the row.
  typedef enum logic [1:0] {BY_MODEL, NO_DIMS, DIMS_FAIL, DIMS_OK} row_chk_e;

  typedef struct packed {
    logic [7:0]  b;
    logic        last;
    row_chk_e    chk;
    logic [15:0] w;
    logic [15:0] h;
  } row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tuser;

  // scanner model state
  phase_t      scan_ph;
  logic [15:0] scan_skip;
  logic [2:0]  scan_idx;
  logic [15:0] scan_hgt;
  logic [7:0]  scan_hi;
  bit          scan_done;

  result_t     pending_dims[$];
  result_t     dims_head;
  logic [7:0]  file_q[$];

  int          burst_left;
  bit          steady;
  bit          hold_req;
  int          sink_cyc;
  int          idle_cycles;
  int          mismatches;
  int          live_bytes;
  int          words_sent;
  int          files_sent;
  int          dims_ok;
  int          dims_fail;
  int          holds_done;
  int          flavour;
  int          cut;

  row_t dir_rows [N_ROWS] = '{
    // bad first start byte; the byte after the answer is dropped
    '{8'h00, 1'b0, DIMS_FAIL, 16'h0000, 16'h0000},
    '{8'h55, 1'b1, NO_DIMS,   16'h0000, 16'h0000},
    // bad second start byte
    '{8'hFF, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'h00, 1'b1, DIMS_FAIL, 16'h0000, 16'h0000},
    // no FF where a marker is due
    '{8'hFF, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'hD8, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'h12, 1'b1, DIMS_FAIL, 16'h0000, 16'h0000},
    // fill byte, D9 marker with length 2, then the file ends early
    '{8'hFF, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'hD8, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'hFF, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'hFF, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'hD9, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'h00, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'h02, 1'b1, DIMS_FAIL, 16'h0000, 16'h0000},
    // marker 00 with a length of 1
    '{8'hFF, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'hD8, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'hFF, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'h00, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'h00, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'h01, 1'b1, DIMS_FAIL, 16'h0000, 16'h0000},
    // progressive frame, widest width, zero height, answer on the last byte
    '{8'hFF, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'hD8, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'hFF, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'hC2, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'h00, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'h11, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'h08, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'h00, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'h00, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'hFF, 1'b0, BY_MODEL,  16'h0000, 16'h0000},
    '{8'hFF, 1'b1, DIMS_OK,   16'hFFFF, 16'h0000}
  };

  jpeg_frame_size_scanner_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Return the scanner model to its idle state: waiting for the first FF.
  task automatic clear_scan();
    scan_ph   = PH_SOI0;
    scan_skip = '0;
    scan_idx  = '0;
    scan_hgt  = '0;
    scan_hi   = '0;
    scan_done = 1'b0;
  endtask

  // Advance the scanner model by one byte; got is set when the byte yields
  // a result word.
  task automatic scan_byte(input logic [7:0] b, input logic last,
                           output bit got, output result_t res);
    logic [15:0] seg_len;
    bit          bad;
    got = 1'b0;
    bad = 1'b0;
    res = '0;
    case (scan_ph)
      PH_SOI0: if (b == MARKER_PREFIX) scan_ph = PH_SOI1; else bad = 1'b1;
      PH_SOI1: if (b == MARKER_SOI) scan_ph = PH_MARK; else bad = 1'b1;
      PH_MARK: if (b == MARKER_PREFIX) scan_ph = PH_FILL; else bad = 1'b1;
      PH_FILL: begin
        // further FF bytes are fill: stay put
        if (b == MARKER_SOF0 || b == MARKER_SOF2) begin
          scan_idx = '0;
          scan_ph  = PH_FRAME;
        end else if (b != MARKER_PREFIX) begin
          scan_ph = PH_LENH;
        end
      end
      PH_LENH: begin
        scan_hi = b;
        scan_ph = PH_LENL;
      end
      PH_LENL: begin
        seg_len = {scan_hi, b};
        if (seg_len < 16'd2) begin
          bad = 1'b1;
        end else if (seg_len == 16'd2) begin
          scan_ph = PH_MARK;
        end else begin
          scan_skip = seg_len - 16'd2;
          scan_ph   = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (scan_skip != '0) scan_skip = scan_skip - 16'd1;
        if (scan_skip == '0) scan_ph = PH_MARK;
      end
      PH_FRAME: begin
        case (scan_idx)
          FRAME_HEIGHT_HI: scan_hgt = {b, 8'h00};
          FRAME_HEIGHT_LO: scan_hgt[7:0] = b;
          FRAME_WIDTH_HI:  scan_hi = b;
          FRAME_WIDTH_LO: begin
            res       = '{1'b1, {scan_hi, b}, scan_hgt};
            got       = 1'b1;
            scan_done = 1'b1;
            scan_ph   = PH_DONE;
          end
          default: ;
        endcase
        if (!got) scan_idx = scan_idx + 3'd1;
      end
      default: ;  // answered: drop the byte
    endcase

    if (bad) begin
      res       = '0;
      got       = 1'b1;
      scan_done = 1'b1;
      scan_ph   = PH_DONE;
    end

    if (last) begin
      // the file ends without an answer: report failure on this byte
      if (!got && !scan_done) begin
        res = '0;
        got = 1'b1;
      end
      clear_scan();
    end
  endtask

  // Offer one byte, hold it until taken, then record what it should yield.
  task automatic send_word(input logic [7:0] b, input logic last, input row_chk_e chk,
                           input logic [15:0] w, input logic [15:0] h);
    bit      got;
    bit      live;
    result_t res;
    int      gap;
    if (burst_left == 0) begin
      if (!steady) begin
        gap = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 4);
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_tdata  = b;
    s_tlast  = last;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    live = !scan_done;
    scan_byte(b, last, got, res);
    case (chk)
      BY_MODEL:  if (got) pending_dims.push_back(res);
      DIMS_FAIL: pending_dims.push_back('0);
      DIMS_OK:   pending_dims.push_back('{1'b1, w, h});
      default: ;
    endcase
    if (live) live_bytes++;
    words_sent++;
    if (last) files_sent++;
    @(negedge clk);
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_word(file_q[i], i == file_q.size() - 1, BY_MODEL, '0, '0);
  endtask

  // Drop the valid and hold until every pending result word has come back.
  task automatic wait_for_dims();
    s_tvalid = 1'b0;
    while (pending_dims.size() != 0) @(negedge clk);
  endtask

  task automatic make_noise();
    int n;
    n = $urandom_range(1, 5);
    file_q.delete();
    repeat (n) file_q.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1) == 0) file_q[0] = MARKER_PREFIX;
  endtask

  function automatic logic [7:0] plain_marker();
    logic [7:0] mk;
    do mk = 8'($urandom_range(0, 255));
    while (mk == MARKER_PREFIX || mk == MARKER_SOF0 || mk == MARKER_SOF2);
    return mk;
  endfunction

  // Build a well-formed file: start pair, a few skipped segments, a frame
  // header with random sizes and a short random tail.
  task automatic build_frame_file();
    int          nseg;
    int          nfill;
    logic [15:0] seg_len;
    file_q.delete();
    file_q.push_back(MARKER_PREFIX);
    file_q.push_back(MARKER_SOI);
    nseg = $urandom_range(0, 2);
    for (int s = 0; s <= nseg; s++) begin
      file_q.push_back(MARKER_PREFIX);
      nfill = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (nfill) file_q.push_back(MARKER_PREFIX);
      if (s == nseg) begin
        file_q.push_back(($urandom_range(0, 1) == 0) ? MARKER_SOF0 : MARKER_SOF2);
        repeat (7) file_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        file_q.push_back(plain_marker());
        // now and then a long segment, so the high length byte is exercised
        seg_len = ($urandom_range(0, 59) == 0) ? 16'($urandom_range(256, 300))
                                               : 16'($urandom_range(2, 7));
        file_q.push_back(seg_len[15:8]);
        file_q.push_back(seg_len[7:0]);
        repeat (int'(seg_len) - 2) file_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    repeat ($urandom_range(0, 2)) file_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic report_word(input bit unexpected, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      if (unexpected)
        $display("%0t: result word with nothing pending: found=%0b w=%0d h=%0d",
                 $realtime, got.found, got.image_width, got.image_height);
      else
        $display("%0t: result word differs: expected found=%0b w=%0d h=%0d, got found=%0b w=%0d h=%0d",
                 $realtime, want.found, want.image_width, want.image_height,
                 got.found, got.image_width, got.image_height);
    end
  endtask

  // Check every taken result word against the oldest pending one.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_dims.size() == 0) begin
        report_word(1'b1, '0, '{m_tuser, m_tdata[15:0], m_tdata[31:16]});
      end else begin
        dims_head = pending_dims.pop_front();
        if (m_tuser !== dims_head.found || m_tdata[15:0] !== dims_head.image_width ||
            m_tdata[31:16] !== dims_head.image_height)
          report_word(1'b0, dims_head, '{m_tuser, m_tdata[15:0], m_tdata[31:16]});
        if (dims_head.found) dims_ok++; else dims_fail++;
      end
    end
  end

  // Count cycles in which neither side moves a word; give up past the limit.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timed out with %0d result words pending", pending_dims.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sink: rotate through stall patterns, and hold off for a long stretch
  // whenever the source asks for it.
  initial begin
    m_tready = 1'b0;
    sink_cyc = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 1'b0;
        holds_done++;
        repeat (SINK_HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      sink_cyc++;
      case (sink_cyc[7:6])
        2'd0: m_tready = 1'b1;
        2'd1: m_tready = ($urandom_range(0, 9) < 7);
        2'd2: m_tready = ($urandom_range(0, 9) < 3);
        default: m_tready = ((sink_cyc % 5) < 2);
      endcase
    end
  end

  // Source: reset, the directed table, then random files.
  initial begin
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tlast     = 1'b0;
    hold_req    = 1'b0;
    steady      = 1'b0;
    burst_left  = 0;
    idle_cycles = 0;
    mismatches  = 0;
    live_bytes  = 0;
    words_sent  = 0;
    files_sent  = 0;
    dims_ok     = 0;
    dims_fail   = 0;
    holds_done  = 0;
    clear_scan();
    repeat (10) @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i])
      send_word(dir_rows[i].b, dir_rows[i].last, dir_rows[i].chk, dir_rows[i].w, dir_rows[i].h);
    wait_for_dims();

    while (words_sent < ITEM_TARGET || files_sent < FILE_TARGET) begin
      if (files_sent == 15 || files_sent == 35) begin
        // keep offering short failing files while the sink holds off, so
        // the result register fills and the input backs up
        steady   = 1'b1;
        hold_req = 1'b1;
        repeat (6) begin
          make_noise();
          send_file();
        end
        steady = 1'b0;
      end else begin
        if (files_sent == 25) wait_for_dims();
        steady  = ($urandom_range(0, 3) == 0);
        flavour = $urandom_range(0, 11);
        build_frame_file();
        if (flavour == 7 || flavour == 8) begin
          // cut the file short somewhere
          cut = $urandom_range(1, file_q.size() - 1);
          while (file_q.size() > cut) void'(file_q.pop_back());
        end else if (flavour == 9) begin
          file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (flavour == 10) begin
          // length field of 0 or 1
          file_q.delete();
          file_q.push_back(MARKER_PREFIX);
          file_q.push_back(MARKER_SOI);
          file_q.push_back(MARKER_PREFIX);
          file_q.push_back(plain_marker());
          file_q.push_back(8'h00);
          file_q.push_back(8'($urandom_range(0, 1)));
          repeat ($urandom_range(0, 2)) file_q.push_back(8'($urandom_range(0, 255)));
        end else if (flavour == 11) begin
          make_noise();
        end
        send_file();
      end
    end

    wait_for_dims();
    repeat (10) @(negedge clk);
    $display("Scanned %0d files in %0d input words (%0d live), with %0d long sink hold-offs",
             files_sent, words_sent, live_bytes, holds_done);
    $display("Checked %0d result words: %0d with sizes, %0d failures; %0d mismatches",
             dims_ok + dims_fail, dims_ok, dims_fail, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
